@@ hw/rtl/gbc_pkg.sv @@
// Shared types and constants for the Gaussian blur convolution block.
// No dependencies; used by gaussian_blur_convolution and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

    localparam int MAX_KERNEL   = 27;
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 4;

    // image store addressed as {row, col, channel}
    localparam int IMG_DEPTH  = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int IMG_AW     = 18;
    localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int COEF_AW    = 10;

    localparam int ACC_W = 34;   // 729 taps of 8x16 products
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    // request functions
    localparam logic [1:0] FUNC_WR_COEF  = 2'd0;
    localparam logic [1:0] FUNC_WR_PIXEL = 2'd1;
    localparam logic [1:0] FUNC_RD_BLUR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_KERNEL_SIZE   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_ZERO_PAD      = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [1:0]  channel;
        logic [15:0] value;
    } req_t;

    typedef struct packed {
        logic [7:0] blurred_pixel;
        logic       status;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/gbc_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 10,
    parameter int DEPTH  = 1024
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gaussian_blur_convolution.sv @@
// Top level of the Gaussian blur convolution block: config registers, request
// sequencer and MAC pipeline. Depends on gbc_pkg and gbc_ram.
//
// Usage:
//   Requests enter on start/request and are taken when start is high and busy
//   is low. Each request yields exactly one result on result, valid for the
//   single cycle in which done is high; the receiver cannot hold it off.
//   Functions: write a kernel coefficient, write a pixel byte, read a blurred
//   pixel. Rejected requests return status 1 and change nothing.
//   Config registers are written on cfg_valid/cfg_ready (always ready) with
//   cfg_index selecting the register; write them only while idle.
// Sequencing:
//   Writes, rejected requests and no-pad border reads go from decode straight
//   back to idle and register done. A blurred read walks all K*K taps, one image
//   and one coefficient RAM read per cycle, then drains the product and
//   accumulate registers and rounds in the finish state before done is registered.
//   One request is in flight at a time; busy is high until its result is out.
// Reset:
//   rst_n clears the sequencer and sets the config registers to K = 3,
//   256 x 256, 3 channels, zero padding. Both stores hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_convolution (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire gbc_pkg::req_t               request,
    output logic                             done,
    output gbc_pkg::result_t                 result,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [gbc_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [gbc_pkg::CFG_DW-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_WALK   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    gbc_pkg::req_t    req_reg;
    gbc_pkg::result_t result_reg;
    logic             done_reg;

    logic [4:0] kernel_size_reg;
    logic [8:0] image_width_reg;
    logic [8:0] image_height_reg;
    logic [2:0] channel_count_reg;
    logic       zero_pad_reg;

    // tap walker
    logic [4:0]                  ti_reg, tj_reg;
    logic [gbc_pkg::COEF_AW-1:0] crow_reg;
    // MAC pipeline
    logic                        v1_reg, in1_reg, last1_reg;
    logic                        v2_reg, last2_reg;
    logic [23:0]                 prod_reg;
    logic [gbc_pkg::ACC_W-1:0]   acc_reg;

    // effective configuration
    logic [4:0] ks_sat, k_eff;
    logic [3:0] half;
    logic [8:0] w_eff, h_eff;
    logic [2:0] nc_eff;

    always_comb
    begin
        ks_sat = (kernel_size_reg > 5'(gbc_pkg::MAX_KERNEL)) ?
                 5'(gbc_pkg::MAX_KERNEL) : kernel_size_reg;
        if (ks_sat[0])
            k_eff = ks_sat;
        else if (ks_sat == 5'd0)
            k_eff = 5'd1;
        else
            k_eff = ks_sat - 5'd1;
        half = k_eff[4:1];

        if (image_width_reg == 9'd0)
            w_eff = 9'd1;
        else if (image_width_reg > 9'(gbc_pkg::MAX_WIDTH))
            w_eff = 9'(gbc_pkg::MAX_WIDTH);
        else
            w_eff = image_width_reg;

        if (image_height_reg == 9'd0)
            h_eff = 9'd1;
        else if (image_height_reg > 9'(gbc_pkg::MAX_HEIGHT))
            h_eff = 9'(gbc_pkg::MAX_HEIGHT);
        else
            h_eff = image_height_reg;

        if (channel_count_reg == 3'd0)
            nc_eff = 3'd1;
        else if (channel_count_reg > 3'(gbc_pkg::MAX_CHANNELS))
            nc_eff = 3'(gbc_pkg::MAX_CHANNELS);
        else
            nc_eff = channel_count_reg;
    end

    // request decode
    logic coef_ok, pix_ok, border, is_coef, is_pixel, is_read, read_go;
    logic [8:0] row9, col9;

    always_comb
    begin
        row9     = {1'b0, req_reg.row};
        col9     = {1'b0, req_reg.col};
        is_coef  = (req_reg.func == gbc_pkg::FUNC_WR_COEF);
        is_pixel = (req_reg.func == gbc_pkg::FUNC_WR_PIXEL);
        is_read  = (req_reg.func == gbc_pkg::FUNC_RD_BLUR);
        coef_ok  = (req_reg.row < {3'b000, k_eff}) && (req_reg.col < {3'b000, k_eff});
        pix_ok   = (row9 < h_eff) && (col9 < w_eff) && ({1'b0, req_reg.channel} < nc_eff);
        border   = !zero_pad_reg &&
                   ((req_reg.row < {4'b0000, half}) || (req_reg.col < {4'b0000, half}) ||
                    (row9 + {5'b00000, half} >= h_eff) ||
                    (col9 + {5'b00000, half} >= w_eff));
        read_go  = is_read && pix_ok && !border;
    end

    // tap position
    logic [9:0] pr, pc;
    logic       tap_inside, last_tap;

    always_comb
    begin
        pr = {2'b00, req_reg.row} + {5'b00000, ti_reg} - {6'b000000, half};
        pc = {2'b00, req_reg.col} + {5'b00000, tj_reg} - {6'b000000, half};
        tap_inside = !pr[9] && (pr[8:0] < h_eff) && !pc[9] && (pc[8:0] < w_eff);
        last_tap   = (ti_reg == k_eff - 5'd1) && (tj_reg == k_eff - 5'd1);
    end

    // stores
    logic                        img_we, coef_we;
    logic [gbc_pkg::IMG_AW-1:0]  img_waddr, img_raddr;
    logic [gbc_pkg::COEF_AW-1:0] coef_waddr, coef_raddr;
    logic [7:0]                  img_wdata, img_rdata;
    logic [15:0]                 coef_rdata;

    always_comb
    begin
        img_we     = (state_reg == S_DECODE) && is_pixel && pix_ok;
        coef_we    = (state_reg == S_DECODE) && is_coef && coef_ok;
        img_waddr  = {req_reg.row, req_reg.col, req_reg.channel};
        img_wdata  = (req_reg.value > 16'd255) ? 8'hFF : req_reg.value[7:0];
        coef_waddr = gbc_pkg::COEF_AW'(req_reg.row[4:0] * 10'(gbc_pkg::MAX_KERNEL)) +
                     gbc_pkg::COEF_AW'(req_reg.col[4:0]);
        img_raddr  = {pr[7:0], pc[7:0], req_reg.channel};
        coef_raddr = crow_reg + gbc_pkg::COEF_AW'(tj_reg);
    end

    gbc_ram #(
        .DATA_W (8),
        .ADDR_W (gbc_pkg::IMG_AW),
        .DEPTH  (gbc_pkg::IMG_DEPTH)
    ) u_img_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    gbc_ram #(
        .DATA_W (16),
        .ADDR_W (gbc_pkg::COEF_AW),
        .DEPTH  (gbc_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (req_reg.value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (start) state_next = S_DECODE;
            S_DECODE: state_next = read_go ? S_WALK : S_IDLE;
            S_WALK:   if (last_tap) state_next = S_DRAIN;
            S_DRAIN:  if (last2_reg) state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_size_reg   <= 5'd3;
            image_width_reg   <= 9'd256;
            image_height_reg  <= 9'd256;
            channel_count_reg <= 3'd3;
            zero_pad_reg      <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gbc_pkg::CFG_KERNEL_SIZE:   kernel_size_reg   <= cfg_data[4:0];
                gbc_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[8:0];
                gbc_pkg::CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[8:0];
                gbc_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[2:0];
                gbc_pkg::CFG_ZERO_PAD:      zero_pad_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // request capture, walker, accumulator
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (state_reg == S_DECODE)
        begin
            ti_reg   <= 5'd0;
            tj_reg   <= 5'd0;
            crow_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (state_reg == S_WALK)
            begin
                if (tj_reg == k_eff - 5'd1)
                begin
                    tj_reg   <= 5'd0;
                    ti_reg   <= ti_reg + 5'd1;
                    crow_reg <= crow_reg + gbc_pkg::COEF_AW'(gbc_pkg::MAX_KERNEL);
                end
                else
                begin
                    tj_reg <= tj_reg + 5'd1;
                end
            end
            if (v2_reg)
            begin
                acc_reg <= acc_reg + gbc_pkg::ACC_W'(prod_reg);
            end
        end
        in1_reg  <= tap_inside;
        // outside taps contribute nothing (zero padding)
        prod_reg <= in1_reg ? (24'(img_rdata) * 24'(coef_rdata)) : 24'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= (state_reg == S_WALK);
            last1_reg <= (state_reg == S_WALK) && last_tap;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
        end
    end

    // result: round half up from Q.16, saturate to 255
    logic [gbc_pkg::ACC_W-1:0] acc_rnd;
    logic [7:0]                pix_sat;

    always_comb
    begin
        acc_rnd = acc_reg + gbc_pkg::ACC_W'(32768);
        pix_sat = (|acc_rnd[gbc_pkg::ACC_W-1:24]) ? 8'hFF : acc_rnd[23:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ((state_reg == S_DECODE) && !read_go) || (state_reg == S_FINISH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH)
        begin
            result_reg.blurred_pixel <= pix_sat;
            result_reg.status        <= 1'b0;
        end
        else if (state_reg == S_DECODE)
        begin
            result_reg.blurred_pixel <= 8'd0;
            result_reg.status        <= is_coef ? !coef_ok :
                                        ((is_pixel || is_read) ? !pix_ok : 1'b1);
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // checks
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_DECODE || $past(state_reg) == S_FINISH))
        else $error("result strobe without a finishing request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.blurred_pixel == 8'd0))
        else $error("rejected request with nonzero pixel");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> (!v1_reg && !v2_reg))
        else $error("rounding before MAC pipeline drained");

endmodule

`default_nettype wire

@@ tb/gbc_tb_pkg.sv @@
// Scoreboard for the Gaussian blur convolution testbench: a predictor of the
// image and coefficient stores and config registers, and the queue of expected results.
// Depends on gbc_pkg.
`timescale 1ns / 1ps

package gbc_tb_pkg;

    import gbc_pkg::*;

    localparam logic [1:0]        FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IW-1:0] CFG_SPARE   = 3'd7;

    function automatic req_t make_req(input logic [1:0] func, input int unsigned row,
                                      input int unsigned col, input int unsigned channel,
                                      input int unsigned value);
        req_t r;
        r.func    = func;
        r.row     = row[7:0];
        r.col     = col[7:0];
        r.channel = channel[1:0];
        r.value   = value[15:0];
        return r;
    endfunction

    // about half the pixel bytes are over 255 and get saturated
    function automatic logic [15:0] random_pixel_value();
        if ($urandom_range(1) == 0)
            return 16'($urandom_range(255));
        return 16'($urandom);
    endfunction

    class blur_scoreboard;
        logic [7:0]  image_mem [IMG_DEPTH];
        bit          image_set [IMG_DEPTH];
        logic [15:0] coef_mem [COEF_DEPTH];
        bit          coef_set [COEF_DEPTH];
        logic [4:0]  kernel_size;
        logic [8:0]  image_width;
        logic [8:0]  image_height;
        logic [2:0]  channel_count;
        logic        zero_pad;
        result_t     pending_results [$];
        int unsigned mismatches;

        function new();
            kernel_size   = 5'd3;
            image_width   = 9'd256;
            image_height  = 9'd256;
            channel_count = 3'd3;
            zero_pad      = 1'b1;
            mismatches    = 0;
        endfunction

        function void set_register(input logic [CFG_IW-1:0] index,
                                   input logic [CFG_DW-1:0] data);
            case (index)
                CFG_KERNEL_SIZE:   kernel_size   = data[4:0];
                CFG_IMAGE_WIDTH:   image_width   = data[8:0];
                CFG_IMAGE_HEIGHT:  image_height  = data[8:0];
                CFG_CHANNEL_COUNT: channel_count = data[2:0];
                CFG_ZERO_PAD:      zero_pad      = data[0];
                default: ;
            endcase
        endfunction

        function int clamp_dim(input int v, input int hi);
            if (v < 1)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        function int eff_kernel();
            int k;
            k = (kernel_size > MAX_KERNEL) ? MAX_KERNEL : int'(kernel_size);
            if (k % 2 == 0)
                k = (k == 0) ? 1 : k - 1;
            return k;
        endfunction

        function int eff_width();
            return clamp_dim(image_width, MAX_WIDTH);
        endfunction

        function int eff_height();
            return clamp_dim(image_height, MAX_HEIGHT);
        endfunction

        function int eff_channels();
            return clamp_dim(channel_count, MAX_CHANNELS);
        endfunction

        function bit in_image(input req_t r);
            return r.row < eff_height() && r.col < eff_width() && r.channel < eff_channels();
        endfunction

        // Blurred value at one pixel. Also counts the store entries the read
        // would touch before they were written, and returns a write for the first.
        function void convolve_at(input logic [7:0] row, input logic [7:0] col,
                                  input logic [1:0] ch, output logic [7:0] pixel,
                                  output int unsigned gaps, output req_t fill);
            int k, w, h, half, ri, ci, pr, pc;
            logic [63:0] acc;
            logic [IMG_AW-1:0] a;
            k     = eff_kernel();
            w     = eff_width();
            h     = eff_height();
            half  = k / 2;
            ri    = row;
            ci    = col;
            acc   = '0;
            gaps  = 0;
            pixel = '0;
            fill  = '0;
            if (!zero_pad && (ri < half || ci < half || ri + half >= h || ci + half >= w))
                return;
            for (int i = 0; i < k; i++) begin
                pr = ri + i - half;
                if (pr < 0 || pr >= h)
                    continue;
                for (int j = 0; j < k; j++) begin
                    pc = ci + j - half;
                    if (pc < 0 || pc >= w)
                        continue;
                    a = {8'(pr), 8'(pc), ch};
                    if (!coef_set[i * MAX_KERNEL + j]) begin
                        if (gaps == 0)
                            fill = make_req(FUNC_WR_COEF, i, j, $urandom, $urandom);
                        gaps++;
                    end
                    if (!image_set[a]) begin
                        if (gaps == 0)
                            fill = make_req(FUNC_WR_PIXEL, pr, pc, ch, random_pixel_value());
                        gaps++;
                    end
                    acc += image_mem[a] * coef_mem[i * MAX_KERNEL + j];
                end
            end
            acc   = (acc + 64'd32768) >> 16;
            pixel = (acc > 64'd255) ? 8'd255 : acc[7:0];
        endfunction

        function void note_request(input req_t r);
            result_t           res;
            logic [7:0]        pixel;
            int unsigned       gaps;
            req_t              fill;
            int                k;
            logic [IMG_AW-1:0] a;
            res = '0;
            k   = eff_kernel();
            a   = {r.row, r.col, r.channel};
            case (r.func)
                FUNC_WR_COEF:
                    if (r.row < k && r.col < k) begin
                        coef_mem[r.row * MAX_KERNEL + r.col] = r.value;
                        coef_set[r.row * MAX_KERNEL + r.col] = 1'b1;
                    end else begin
                        res.status = 1'b1;
                    end
                FUNC_WR_PIXEL, FUNC_RD_BLUR:
                    if (!in_image(r)) begin
                        res.status = 1'b1;
                    end else if (r.func == FUNC_WR_PIXEL) begin
                        image_mem[a] = (r.value > 16'd255) ? 8'hFF : r.value[7:0];
                        image_set[a] = 1'b1;
                    end else begin
                        convolve_at(r.row, r.col, r.channel, pixel, gaps, fill);
                        res.blurred_pixel = pixel;
                    end
                default:
                    res.status = 1'b1;
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: blurred_pixel %0d status %0d",
                       got.blurred_pixel, got.status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.blurred_pixel !== want.blurred_pixel) begin
                $error("blurred_pixel: expected %0d, got %0d",
                       want.blurred_pixel, got.blurred_pixel);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

endpackage

@@ tb/gaussian_blur_convolution_tb.sv @@
// Top-level testbench for gaussian_blur_convolution: directed corner cases, then
// random phases over several register settings, checked by blur_scoreboard.
// Depends on gbc_pkg, gbc_tb_pkg and the block's RTL.
`timescale 1ns / 1ps

module gaussian_blur_convolution_tb;

    import gbc_pkg::*;
    import gbc_tb_pkg::*;

    localparam int PHASES          = 12;
    localparam int FIXED_PHASES    = 8;
    localparam int ITEMS_PER_PHASE = 67;
    localparam int FILL_LIMIT      = 60;
    localparam int WATCHDOG_LIMIT  = 4000;

    // raw register values, out-of-range ones included
    localparam int unsigned PHASE_K   [FIXED_PHASES] = '{3, 5, 0, 4, 31, 27, 9, 2};
    localparam int unsigned PHASE_W   [FIXED_PHASES] = '{8, 7, 0, 256, 4, 5, 12, 300};
    localparam int unsigned PHASE_H   [FIXED_PHASES] = '{8, 6, 1, 511, 3, 6, 10, 2};
    localparam int unsigned PHASE_CH  [FIXED_PHASES] = '{1, 2, 7, 3, 3, 0, 2, 4};
    localparam int unsigned PHASE_PAD [FIXED_PHASES] = '{1, 0, 1, 1, 1, 0, 1, 0};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    req_t              request   = '0;
    logic              done;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    blur_scoreboard blur_sb;
    int unsigned    quiet_cycles = 0;
    int unsigned    idle_pct     = 0;

    // pixel being prepared for a blurred read
    bit         have_target = 1'b0;
    logic [7:0] target_row;
    logic [7:0] target_col;
    logic [1:0] target_ch;

    gaussian_blur_convolution dut (
        .clk,
        .rst_n,
        .start,
        .busy,
        .request,
        .done,
        .result,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                blur_sb.check_result(result);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // leaves start high so the next request can follow back to back
    task automatic send_request(input req_t r);
        start   <= 1'b1;
        request <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        blur_sb.note_request(r);
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (blur_sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IW-1:0] index,
                                  input logic [CFG_DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        blur_sb.set_register(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits are junk; only the field width counts
    task automatic configure(input int unsigned k, input int unsigned w, input int unsigned h,
                             input int unsigned nc, input int unsigned pad);
        wait_drained();
        write_register(CFG_KERNEL_SIZE,   {11'($urandom), 5'(k)});
        write_register(CFG_IMAGE_WIDTH,   {7'($urandom), 9'(w)});
        write_register(CFG_IMAGE_HEIGHT,  {7'($urandom), 9'(h)});
        write_register(CFG_CHANNEL_COUNT, {13'($urandom), 3'(nc)});
        write_register(CFG_ZERO_PAD,      {15'($urandom), 1'(pad)});
        have_target = 1'b0;
    endtask

    // Mostly builds up a read: writes whatever the target pixel's window still
    // lacks, then reads it. The rest are loose writes and rejected requests.
    task automatic pick_request(output req_t r);
        int unsigned roll;
        int unsigned sel;
        int unsigned gaps;
        int          k;
        int          w;
        int          h;
        int          nc;
        logic [7:0]  pixel;
        req_t        fill;
        k    = blur_sb.eff_kernel();
        w    = blur_sb.eff_width();
        h    = blur_sb.eff_height();
        nc   = blur_sb.eff_channels();
        roll = $urandom_range(99);
        if (!have_target && roll < 55)
        begin
            for (int t = 0; t < 8 && !have_target; t++)
            begin
                target_row = 8'($urandom_range(h - 1));
                target_col = 8'($urandom_range(w - 1));
                target_ch  = 2'($urandom_range(nc - 1));
                blur_sb.convolve_at(target_row, target_col, target_ch, pixel, gaps, fill);
                have_target = (gaps <= FILL_LIMIT);
            end
        end
        if (have_target)
        begin
            blur_sb.convolve_at(target_row, target_col, target_ch, pixel, gaps, fill);
            if (gaps == 0)
            begin
                r = make_req(FUNC_RD_BLUR, target_row, target_col, target_ch, $urandom);
                // sometimes read the same pixel again
                if ($urandom_range(3) != 0)
                    have_target = 1'b0;
            end
            else
                r = fill;
        end
        else if (roll < 75)
            r = make_req(FUNC_WR_PIXEL, $urandom_range(h - 1), $urandom_range(w - 1),
                         $urandom_range(nc - 1), random_pixel_value());
        else if (roll < 85)
            r = make_req(FUNC_WR_COEF, $urandom_range(k - 1), $urandom_range(k - 1),
                         $urandom, $urandom);
        else
        begin
            sel = $urandom_range(2);
            r   = make_req(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
            if (sel == 0)
            begin
                r.func = FUNC_WR_COEF;
                if ($urandom_range(1) == 0)
                    r.row = 8'($urandom_range(255, k));
                else
                    r.col = 8'($urandom_range(255, k));
            end
            else if (sel == 1)
            begin
                r.func = ($urandom_range(1) == 0) ? FUNC_WR_PIXEL : FUNC_RD_BLUR;
                if (blur_sb.in_image(r))
                begin
                    if (h < MAX_HEIGHT)
                        r.row = 8'($urandom_range(255, h));
                    else if (w < MAX_WIDTH)
                        r.col = 8'($urandom_range(255, w));
                    else if (nc < MAX_CHANNELS)
                        r.channel = 2'($urandom_range(3, nc));
                    else
                        r.func = FUNC_UNUSED;
                end
            end
        end
    endtask

    initial
    begin
        req_t        r;
        int unsigned k;
        int unsigned w;
        int unsigned h;
        int unsigned nc;
        int unsigned pad;
        blur_sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: K = 3, 256 x 256, 3 channels, zero padding.
        // Window of (0,0) ch 0 is taps (1..2, 1..2) over pixels (0..1, 0..1).
        send_request(make_req(FUNC_WR_COEF, 1, 1, 0, 16'h8000));
        send_request(make_req(FUNC_WR_COEF, 1, 2, 0, 0));
        send_request(make_req(FUNC_WR_COEF, 2, 1, 0, 0));
        send_request(make_req(FUNC_WR_COEF, 2, 2, 0, 0));
        send_request(make_req(FUNC_WR_PIXEL, 0, 0, 0, 1));
        send_request(make_req(FUNC_WR_PIXEL, 0, 1, 0, 0));
        send_request(make_req(FUNC_WR_PIXEL, 1, 0, 0, 0));
        send_request(make_req(FUNC_WR_PIXEL, 1, 1, 0, 0));
        // exactly one half: rounds up to 1
        send_request(make_req(FUNC_RD_BLUR, 0, 0, 0, 0));
        // oversized pixel bytes, then a sum that saturates
        send_request(make_req(FUNC_WR_PIXEL, 0, 0, 0, 16'hFFFF));
        send_request(make_req(FUNC_WR_COEF, 2, 2, 0, 16'hFFFF));
        send_request(make_req(FUNC_WR_PIXEL, 1, 1, 0, 300));
        send_request(make_req(FUNC_RD_BLUR, 0, 0, 0, 0));
        // rejected: taps outside the kernel, channel outside the image, bad function; one valid corner write
        send_request(make_req(FUNC_WR_COEF, 3, 0, 0, 16'h1234));
        send_request(make_req(FUNC_WR_COEF, 255, 255, 3, 16'hFFFF));
        send_request(make_req(FUNC_WR_PIXEL, 0, 0, 3, 16'h00AA));
        send_request(make_req(FUNC_RD_BLUR, 0, 0, 3, 0));
        send_request(make_req(FUNC_WR_PIXEL, 255, 255, 2, 16'h00FF));
        send_request(make_req(FUNC_UNUSED, 255, 255, 3, 16'hFFFF));
        // no-pad border read
        wait_drained();
        write_register(CFG_ZERO_PAD, 16'h0000);
        send_request(make_req(FUNC_RD_BLUR, 0, 0, 0, 0));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < FIXED_PHASES)
            begin
                k   = PHASE_K[p];
                w   = PHASE_W[p];
                h   = PHASE_H[p];
                nc  = PHASE_CH[p];
                pad = PHASE_PAD[p];
            end
            else
            begin
                k   = $urandom_range(31);
                w   = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(16);
                h   = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(16);
                nc  = $urandom_range(7);
                pad = $urandom_range(1);
            end
            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 72;
                default: idle_pct = 16;
            endcase
            configure(k, w, h, nc, pad);
            if (p == 0)
                write_register(CFG_SPARE, 16'($urandom));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick_request(r);
                send_request(r);
                sender_gap();
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (blur_sb.mismatches == 0 && blur_sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ gaussian_blur_convolution.f @@
hw/rtl/gbc_pkg.sv
hw/rtl/gbc_ram.sv
hw/rtl/gaussian_blur_convolution.sv
tb/gbc_tb_pkg.sv
tb/gaussian_blur_convolution_tb.sv
